/* rtl/tftp_rr_pkg.sv */
// Shared types, codes and constants for the TFTP read receiver.
package tftp_rr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_DONE   = 2'd2,
    PH_FAILED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_RRQ  = 2'd1,
    K_ACK  = 2'd2,
    K_ERR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_PKT     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_WELL_KNOWN_PORT    = 2'd0,
    CFG_RETRY_LIMIT        = 2'd1,
    CFG_DEFAULT_BLOCK_SIZE = 2'd2
  } cfg_idx_t;

  localparam logic [7:0]  OP_DATA      = 8'h03;
  localparam logic [7:0]  OP_MAX_KNOWN = 8'h05;
  localparam logic [2:0]  E_ILLEGAL    = 3'd4;
  localparam logic [2:0]  E_UNKNOWN_ID = 3'd5;
  localparam logic [15:0] HDR_BYTES    = 16'd4;

  localparam logic [15:0] DEF_WELL_KNOWN_PORT = 16'd69;
  localparam logic [7:0]  DEF_RETRY_LIMIT     = 8'd5;
  localparam logic [15:0] DEF_BLOCK_SIZE      = 16'd512;

  localparam int unsigned Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        from_server_ip;
    logic [15:0] src_port;
    logic [7:0]  pkt_opcode;
    logic [15:0] block_num;
    logic [15:0] pkt_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [15:0] send_block;
    logic [2:0]  err_code;
    logic [15:0] dest_port;
    logic        write_payload;
    logic [15:0] payload_length;
    logic        done_res;
    logic        failed;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic        cmd_ok;
    cmd_t        cmd;
    logic        from_ip;
    logic [15:0] sport;
    logic        is_data;
    logic        op_illegal;
    logic [15:0] blk;
    logic [15:0] pay;
  } event_t;

endpackage

/* rtl/tftp_rr_front.sv */
// Event classifier and event queue feeding the transfer engine.
module tftp_rr_front
  import tftp_rr_pkg::*;
#(
  parameter int unsigned DEPTH = Q_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_pop,
  output event_t   q_head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  event_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  event_t             cls;
  logic               push;
  logic               pop;

  always_comb begin
    cls            = '0;
    cls.valid      = 1'b1;
    cls.cmd_ok     = (in_data.cmd != CMD_UNUSED);
    cls.cmd        = cmd_t'(in_data.cmd);
    cls.from_ip    = in_data.from_server_ip;
    cls.sport      = in_data.src_port;
    cls.is_data    = (in_data.pkt_opcode == OP_DATA);
    cls.op_illegal = (in_data.pkt_opcode > OP_MAX_KNOWN);
    cls.blk        = in_data.block_num;
    cls.pay        = (in_data.pkt_len >= HDR_BYTES) ?
                     (in_data.pkt_len - HDR_BYTES) : 16'd0;
  end

  assign in_stall = (count == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count != '0);

  always_comb begin
    q_head       = slots[rd_ptr];
    q_head.valid = (count != '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

/* rtl/tftp_rr_back.sv */
// Transfer engine: session state, configuration registers and result register.
module tftp_rr_back
  import tftp_rr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  event_t    q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] well_known_port;
  logic [7:0]  retry_limit;
  logic [15:0] default_block_size;

  phase_t      phase, phase_next;
  logic [15:0] transfer_id, transfer_id_next;
  logic        id_known, id_known_next;
  logic [15:0] last_block, last_block_next;
  logic [7:0]  retry_count, retry_count_next;
  logic [15:0] block_size, block_size_next;
  logic        first_seen, first_seen_next;

  out_item_t   res;
  logic [7:0]  rc_inc;
  logic        retry_hit;
  logic [15:0] expect_blk;
  logic [15:0] tid_eff;
  logic [15:0] bs_eff;

  assign cfg_ready = 1'b1;
  assign q_pop     = q_head.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      well_known_port    <= DEF_WELL_KNOWN_PORT;
      retry_limit        <= DEF_RETRY_LIMIT;
      default_block_size <= DEF_BLOCK_SIZE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WELL_KNOWN_PORT:    well_known_port    <= cfg_data;
        CFG_RETRY_LIMIT:        retry_limit        <= cfg_data[7:0];
        CFG_DEFAULT_BLOCK_SIZE: default_block_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    res              = '0;
    phase_next       = phase;
    transfer_id_next = transfer_id;
    id_known_next    = id_known;
    last_block_next  = last_block;
    retry_count_next = retry_count;
    block_size_next  = block_size;
    first_seen_next  = first_seen;
    rc_inc     = (retry_count != 8'hFF) ? retry_count + 8'd1 : retry_count;
    retry_hit  = (rc_inc >= retry_limit);
    expect_blk = last_block + 16'd1;
    tid_eff    = id_known ? transfer_id : q_head.sport;
    bs_eff     = first_seen ? block_size :
                 ((q_head.pay > default_block_size) ? q_head.pay : default_block_size);
    if (q_head.cmd_ok) begin
      unique case (q_head.cmd)
        CMD_START: begin
          phase_next       = PH_ACTIVE;
          transfer_id_next = '0;
          id_known_next    = 1'b0;
          last_block_next  = '0;
          retry_count_next = '0;
          block_size_next  = default_block_size;
          first_seen_next  = 1'b0;
          res.send_kind    = K_RRQ;
          res.dest_port    = well_known_port;
        end
        CMD_PKT: begin
          if (phase == PH_ACTIVE && q_head.from_ip) begin
            if (!id_known) begin
              transfer_id_next = q_head.sport;
              id_known_next    = 1'b1;
            end
            if (q_head.sport != tid_eff) begin
              res.send_kind  = K_ERR;
              res.err_code   = E_UNKNOWN_ID;
              res.dest_port  = q_head.sport;
            end else begin
              if (!first_seen) begin
                block_size_next = bs_eff;
                first_seen_next = 1'b1;
              end
              if (!q_head.is_data) begin
                if (q_head.op_illegal) begin
                  res.send_kind  = K_ERR;
                  res.err_code   = E_ILLEGAL;
                  res.dest_port  = tid_eff;
                end
                retry_count_next = rc_inc;
                if (retry_hit) begin
                  phase_next = PH_FAILED;
                  res.failed = 1'b1;
                end
              end else if (q_head.blk == expect_blk) begin
                last_block_next    = expect_blk;
                retry_count_next   = '0;
                res.send_kind      = K_ACK;
                res.send_block     = expect_blk;
                res.dest_port      = tid_eff;
                res.write_payload  = 1'b1;
                res.payload_length = q_head.pay;
                if (q_head.pay < bs_eff) begin
                  res.done_res = 1'b1;
                  phase_next   = PH_DONE;
                end
              end else if (q_head.blk == last_block) begin
                res.send_kind  = K_ACK;
                res.send_block = last_block;
                res.dest_port  = tid_eff;
              end else begin
                retry_count_next = rc_inc;
                if (retry_hit) begin
                  phase_next = PH_FAILED;
                  res.failed = 1'b1;
                end
              end
            end
          end
        end
        CMD_TIMEOUT: begin
          if (phase == PH_ACTIVE) begin
            retry_count_next = rc_inc;
            if (retry_hit) begin
              phase_next = PH_FAILED;
              res.failed = 1'b1;
            end else if (last_block != 16'd0) begin
              res.send_kind  = K_ACK;
              res.send_block = last_block;
              res.dest_port  = id_known ? transfer_id : well_known_port;
            end else begin
              res.send_kind = K_RRQ;
              res.dest_port = well_known_port;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      transfer_id <= '0;
      id_known    <= 1'b0;
      last_block  <= '0;
      retry_count <= '0;
      block_size  <= DEF_BLOCK_SIZE;
      first_seen  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        phase       <= phase_next;
        transfer_id <= transfer_id_next;
        id_known    <= id_known_next;
        last_block  <= last_block_next;
        retry_count <= retry_count_next;
        block_size  <= block_size_next;
        first_seen  <= first_seen_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= res;
    end
  end

  a_fail_phase: assert property (@(posedge clk) disable iff (rst)
    (q_pop && res.failed) |=> (phase == PH_FAILED))
    else $error("failed result without failed phase");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    (q_pop && res.done_res) |=> (phase == PH_DONE) && (retry_count == 8'd0))
    else $error("done result without done phase");

  a_write_is_ack: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.write_payload) |-> (out_data.send_kind == K_ACK))
    else $error("payload write without ack");

endmodule

/* rtl/tftp_read_receiver.sv */
// Top level of the TFTP read receiver: event queue in front of the transfer engine.
// Unless the output stalls, accepts one event word per cycle and returns exactly one
// result word per event, in order. An accepted event sits in a queue of QUEUE_DEPTH
// words and moves from its head to the result register when the output is not stalled;
// the rate is set by the transfer engine, which updates the session state for one
// event per cycle. Input stall rises only when the queue is full. Configuration writes
// are always ready and must be issued while no events are in flight.
module tftp_read_receiver
  import tftp_rr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  event_t q_head;
  logic   q_pop;

  tftp_rr_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  tftp_rr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* tb/sv/tb_tftp_read_receiver.sv */
// Self-checking testbench for the TFTP read receiver: directed table and random sessions.
`timescale 1ns / 1ps

module tb_tftp_read_receiver;
  import tftp_rr_pkg::*;

  typedef struct {
    in_item_t  w;
    bit        typed;
    out_item_t r;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // receiver-side model state and its copy of the registers
  phase_t      st_phase = PH_IDLE;
  logic [15:0] st_tid = '0;
  logic        st_id_known = 1'b0;
  logic [15:0] st_last = '0;
  logic [7:0]  st_retries = '0;
  logic [15:0] st_bsize = DEF_BLOCK_SIZE;
  logic        st_first = 1'b0;
  logic [15:0] cf_port = DEF_WELL_KNOWN_PORT;
  logic [7:0]  cf_limit = DEF_RETRY_LIMIT;
  logic [15:0] cf_dbs = DEF_BLOCK_SIZE;

  out_item_t   reply_q[$];
  int unsigned mismatches = 0;
  int          burst_left = 0;
  int          budget = 0;
  bit          hold_req = 1'b0;

  tftp_read_receiver DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic in_item_t mk_in(logic [1:0] c, logic ip, logic [15:0] p, logic [7:0] op,
                                     logic [15:0] b, logic [15:0] len);
    in_item_t w;
    w.cmd = c;
    w.from_server_ip = ip;
    w.src_port = p;
    w.pkt_opcode = op;
    w.block_num = b;
    w.pkt_len = len;
    return w;
  endfunction

  function automatic out_item_t mk_out(logic [1:0] k, logic [2:0] ec, logic [15:0] dp,
                                       logic fl);
    out_item_t r;
    r = '0;
    r.send_kind = k;
    r.err_code = ec;
    r.dest_port = dp;
    r.failed = fl;
    return r;
  endfunction

  function automatic logic bump_retry();
    if (st_retries != 8'hFF) st_retries++;
    if (st_retries >= cf_limit) begin
      st_phase = PH_FAILED;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_reply(in_item_t w);
    out_item_t   r;
    logic [15:0] pay;
    logic [15:0] nxt;
    r = '0;
    pay = (w.pkt_len >= HDR_BYTES) ? w.pkt_len - HDR_BYTES : 16'd0;
    nxt = st_last + 16'd1;
    if (w.cmd == CMD_START) begin
      st_phase = PH_ACTIVE;
      st_tid = '0;
      st_id_known = 1'b0;
      st_last = '0;
      st_retries = '0;
      st_bsize = cf_dbs;
      st_first = 1'b0;
      r.send_kind = K_RRQ;
      r.dest_port = cf_port;
    end else if (w.cmd == CMD_PKT && st_phase == PH_ACTIVE && w.from_server_ip) begin
      if (!st_id_known) begin
        st_tid = w.src_port;
        st_id_known = 1'b1;
      end
      if (w.src_port != st_tid) begin
        r.send_kind = K_ERR;
        r.err_code = E_UNKNOWN_ID;
        r.dest_port = w.src_port;
      end else begin
        if (!st_first) begin
          st_bsize = (pay > cf_dbs) ? pay : cf_dbs;
          st_first = 1'b1;
        end
        if (w.pkt_opcode != OP_DATA) begin
          if (w.pkt_opcode > OP_MAX_KNOWN) begin
            r.send_kind = K_ERR;
            r.err_code = E_ILLEGAL;
            r.dest_port = st_tid;
          end
          r.failed = bump_retry();
        end else if (w.block_num == nxt) begin
          st_last = nxt;
          st_retries = '0;
          r.send_kind = K_ACK;
          r.send_block = nxt;
          r.dest_port = st_tid;
          r.write_payload = 1'b1;
          r.payload_length = pay;
          if (pay < st_bsize) begin
            r.done_res = 1'b1;
            st_phase = PH_DONE;
          end
        end else if (w.block_num == st_last) begin
          r.send_kind = K_ACK;
          r.send_block = st_last;
          r.dest_port = st_tid;
        end else begin
          r.failed = bump_retry();
        end
      end
    end else if (w.cmd == CMD_TIMEOUT && st_phase == PH_ACTIVE) begin
      if (bump_retry()) begin
        r.failed = 1'b1;
      end else if (st_last != 16'd0) begin
        r.send_kind = K_ACK;
        r.send_block = st_last;
        r.dest_port = st_id_known ? st_tid : cf_port;
      end else begin
        r.send_kind = K_RRQ;
        r.dest_port = cf_port;
      end
    end
    return r;
  endfunction

  task automatic send_word(in_item_t w, bit typed, out_item_t tv);
    out_item_t p;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    p = predict_reply(w);
    reply_q.push_back(typed ? tv : p);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_WELL_KNOWN_PORT:    cf_port = v;
      CFG_RETRY_LIMIT:        cf_limit = v[7:0];
      CFG_DEFAULT_BLOCK_SIZE: cf_dbs = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one read transfer: mostly in-order data with random faults mixed in
  task automatic run_session(int blocks);
    in_item_t    w;
    logic [15:0] tid;
    logic [15:0] bs;
    logic [15:0] pay;
    int          r;
    bit          counts;
    tid = 16'($urandom);
    send_word(mk_in(CMD_START, 1'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                    16'($urandom_range(4, 65468))), 1'b0, '0);
    budget--;
    while (blocks > 0 && budget > 0 && st_phase == PH_ACTIVE) begin
      r = $urandom_range(0, 99);
      counts = 1'b1;
      bs = st_first ? st_bsize : cf_dbs;
      w = mk_in(CMD_PKT, 1'b1, st_id_known ? st_tid : tid, OP_DATA, st_last + 16'd1,
                bs + HDR_BYTES);
      if (r < 62) begin
        blocks--;
        if (blocks == 0) pay = 16'($urandom_range(0, bs - 1));
        else if (!st_first && $urandom_range(0, 3) == 0) pay = 16'($urandom_range(bs, 65464));
        else pay = bs;
        w.pkt_len = pay + HDR_BYTES;
      end else if (r < 70) begin
        w.block_num = st_last;
      end else if (r < 76) begin
        w = mk_in(CMD_TIMEOUT, 1'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                  16'($urandom_range(4, 65468)));
      end else if (r < 80) begin
        w.src_port = 16'(w.src_port + $urandom_range(1, 65535));
      end else if (r < 84) begin
        w.from_server_ip = 1'b0;
        w.src_port = 16'($urandom);
        counts = 1'b0;
      end else if (r < 88) begin
        w.block_num = 16'($urandom);
      end else if (r < 92) begin
        w.pkt_opcode = 8'($urandom_range(0, 255));
        if (w.pkt_opcode == OP_DATA) w.pkt_opcode = OP_MAX_KNOWN + 8'd1;
      end else if (r < 94) begin
        w.cmd = CMD_UNUSED;
        counts = 1'b0;
      end else if (r < 96) begin
        w.cmd = CMD_START;
      end else begin
        w = mk_in(2'($urandom_range(0, 3)), 1'($urandom), 16'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom_range(4, 65468)));
      end
      send_word(w, 1'b0, '0);
      if (counts) budget--;
    end
  endtask

  initial begin : rx_side
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(4, 40);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ~out_stall;
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  task automatic note_miss(string what, int unsigned e, int unsigned a);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s: expected %0d, got %0d", $time, what, e, a);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t e;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (reply_q.size() == 0) begin
        note_miss("unexpected word, send_kind", 0, 32'(out_data.send_kind));
      end else begin
        e = reply_q.pop_front();
        if (e.send_kind !== out_data.send_kind)
          note_miss("send_kind", 32'(e.send_kind), 32'(out_data.send_kind));
        if (e.send_block !== out_data.send_block)
          note_miss("send_block", 32'(e.send_block), 32'(out_data.send_block));
        if (e.err_code !== out_data.err_code)
          note_miss("err_code", 32'(e.err_code), 32'(out_data.err_code));
        if (e.dest_port !== out_data.dest_port)
          note_miss("dest_port", 32'(e.dest_port), 32'(out_data.dest_port));
        if (e.write_payload !== out_data.write_payload)
          note_miss("write_payload", 32'(e.write_payload), 32'(out_data.write_payload));
        if (e.payload_length !== out_data.payload_length)
          note_miss("payload_length", 32'(e.payload_length), 32'(out_data.payload_length));
        if (e.done_res !== out_data.done_res)
          note_miss("done_res", 32'(e.done_res), 32'(out_data.done_res));
        if (e.failed !== out_data.failed)
          note_miss("failed", 32'(e.failed), 32'(out_data.failed));
      end
    end
  end

  initial begin : main
    dir_row_t    rows[26];
    out_item_t   none;
    int          i;
    int          ph;

    none = '0;
    rows[0]  = '{mk_in(CMD_PKT, 1, 16'd1000, OP_DATA, 16'd1, 16'd516), 1, none};
    rows[1]  = '{mk_in(CMD_TIMEOUT, 0, 16'd0, 8'd0, 16'd0, 16'd4), 1, none};
    rows[2]  = '{mk_in(CMD_UNUSED, 1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd65468), 1, none};
    rows[3]  = '{mk_in(CMD_START, 0, 16'd0, 8'd0, 16'd0, 16'd4), 1,
                 mk_out(K_RRQ, 3'd0, DEF_WELL_KNOWN_PORT, 0)};
    rows[4]  = '{mk_in(CMD_TIMEOUT, 0, 16'd0, 8'd0, 16'd0, 16'd4), 1,
                 mk_out(K_RRQ, 3'd0, DEF_WELL_KNOWN_PORT, 0)};
    rows[5]  = '{mk_in(CMD_PKT, 0, 16'd0, OP_DATA, 16'd1, 16'd516), 1, none};
    rows[6]  = '{mk_in(CMD_PKT, 1, 16'hFFFF, OP_DATA, 16'd0, 16'd4), 0, none};
    rows[7]  = '{mk_in(CMD_PKT, 1, 16'h1234, OP_DATA, 16'd1, 16'd516), 1,
                 mk_out(K_ERR, E_UNKNOWN_ID, 16'h1234, 0)};
    rows[8]  = '{mk_in(CMD_PKT, 1, 16'h0000, OP_DATA, 16'd1, 16'd516), 1,
                 mk_out(K_ERR, E_UNKNOWN_ID, 16'h0000, 0)};
    rows[9]  = '{mk_in(CMD_PKT, 1, 16'hFFFF, 8'hFF, 16'd1, 16'd516), 1,
                 mk_out(K_ERR, E_ILLEGAL, 16'hFFFF, 0)};
    rows[10] = '{mk_in(CMD_PKT, 1, 16'hFFFF, 8'h00, 16'd1, 16'd516), 0, none};
    rows[11] = '{mk_in(CMD_PKT, 1, 16'hFFFF, OP_MAX_KNOWN, 16'd1, 16'd516), 0, none};
    rows[12] = '{mk_in(CMD_PKT, 1, 16'hFFFF, OP_DATA, 16'd1, 16'd516), 0, none};
    rows[13] = '{mk_in(CMD_PKT, 1, 16'hFFFF, OP_DATA, 16'd1, 16'd516), 0, none};
    rows[14] = '{mk_in(CMD_PKT, 1, 16'hFFFF, OP_DATA, 16'hFFFF, 16'd516), 0, none};
    rows[15] = '{mk_in(CMD_TIMEOUT, 1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd65468), 0, none};
    rows[16] = '{mk_in(CMD_PKT, 1, 16'hFFFF, OP_DATA, 16'd2, 16'd65468), 0, none};
    rows[17] = '{mk_in(CMD_PKT, 1, 16'hFFFF, OP_DATA, 16'd3, 16'd2), 0, none};
    rows[18] = '{mk_in(CMD_TIMEOUT, 1, 16'hFFFF, 8'd0, 16'd0, 16'd4), 1, none};
    rows[19] = '{mk_in(CMD_START, 1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd65468), 1,
                 mk_out(K_RRQ, 3'd0, DEF_WELL_KNOWN_PORT, 0)};
    rows[20] = '{mk_in(CMD_PKT, 1, 16'd0, OP_MAX_KNOWN + 8'd1, 16'hFFFF, 16'd65468), 0, none};
    rows[21] = '{mk_in(CMD_TIMEOUT, 0, 16'd0, 8'd0, 16'd0, 16'd4), 0, none};
    rows[22] = '{mk_in(CMD_TIMEOUT, 0, 16'd0, 8'd0, 16'd0, 16'd4), 0, none};
    rows[23] = '{mk_in(CMD_TIMEOUT, 0, 16'd0, 8'd0, 16'd0, 16'd4), 0, none};
    rows[24] = '{mk_in(CMD_TIMEOUT, 0, 16'd0, 8'd0, 16'd0, 16'd4), 1,
                 mk_out(K_NONE, 3'd0, 16'd0, 1)};
    rows[25] = '{mk_in(CMD_PKT, 1, 16'd0, OP_DATA, 16'd1, 16'd100), 1, none};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < 26; i++) send_word(rows[i].w, rows[i].typed, rows[i].r);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_WELL_KNOWN_PORT, 16'h0000);
          write_reg(CFG_RETRY_LIMIT, 16'd1);
          write_reg(CFG_DEFAULT_BLOCK_SIZE, 16'd8);
        end
        1: begin
          write_reg(CFG_WELL_KNOWN_PORT, 16'hFFFF);
          write_reg(CFG_RETRY_LIMIT, 16'd255);
          write_reg(CFG_DEFAULT_BLOCK_SIZE, 16'd65464);
        end
        default: begin
          write_reg(CFG_WELL_KNOWN_PORT, 16'($urandom));
          write_reg(CFG_RETRY_LIMIT, 16'($urandom_range(1, 8)));
          write_reg(CFG_DEFAULT_BLOCK_SIZE, 16'($urandom_range(8, 700)));
        end
      endcase
      if (ph == 2) hold_req = 1'b1;
      budget = 85;
      while (budget > 0) run_session($urandom_range(1, 12));
      drain();
    end

    repeat (16) @(posedge clk);

    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
